### rtl/slrs_pkg.sv
package slrs_pkg;

	// Fixed field widths
	localparam int POS_BITS      = 24;
	localparam int GRID_SIZE_DEF = 512;
	localparam int REST_W        = 23;
	localparam int SGAIN_W       = 16;
	localparam int MGAIN_W       = 20;
	localparam int THR_W         = 23;
	localparam int DGAIN_W       = 16;
	localparam int COLS_W        = 10;
	localparam int ROWS_W        = 16;
	localparam int CFG_IDX_W     = 3;
	localparam int CFG_DATA_W    = 23;

	// Datapath widths
	localparam int MAG_W   = POS_BITS + 1;
	localparam int ROOT_W  = POS_BITS + 2;
	localparam int SQ_W    = 2 * ROOT_W;
	localparam int SMAG_W  = (ROOT_W > REST_W) ? ROOT_W : REST_W;
	localparam int TERM_W  = SMAG_W + 1;
	localparam int PROD_W  = MAG_W + SMAG_W;
	localparam int GPROD_W = TERM_W + SGAIN_W;
	localparam int ACC_W   = GPROD_W + 3;
	localparam int FORCE_W = ACC_W - 16;
	localparam int STEP_W  = FORCE_W + MGAIN_W;
	localparam int EMIT_W  = COLS_W + 1;

	// Register reset values
	localparam logic [REST_W-1:0]  REST_STRAIGHT_RST = REST_W'(10460);
	localparam logic [REST_W-1:0]  REST_DIAGONAL_RST = REST_W'(14793);
	localparam logic [SGAIN_W-1:0] SPRING_GAIN_RST   = SGAIN_W'(655);
	localparam logic [MGAIN_W-1:0] MOVE_GAIN_RST     = MGAIN_W'(65536);
	localparam logic [THR_W-1:0]   STEP_THR_RST      = THR_W'(523);
	localparam logic [DGAIN_W-1:0] DAMPED_GAIN_RST   = DGAIN_W'(2092);
	localparam logic [COLS_W-1:0]  GRID_COLS_RST     = COLS_W'(402);
	localparam logic [ROWS_W-1:0]  GRID_ROWS_RST     = ROWS_W'(402);

	localparam logic ACT_NODE  = 1'b0;
	localparam logic ACT_DRAIN = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_REST_STRAIGHT = 3'd0,
		REG_REST_DIAGONAL = 3'd1,
		REG_SPRING_GAIN   = 3'd2,
		REG_MOVE_GAIN     = 3'd3,
		REG_STEP_THR      = 3'd4,
		REG_DAMPED_GAIN   = 3'd5,
		REG_GRID_COLS     = 3'd6,
		REG_GRID_ROWS     = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic                       action;
		logic signed [POS_BITS-1:0] pos_x;
		logic signed [POS_BITS-1:0] pos_y;
		logic                       fixed;
	} in_word_t;

	typedef struct packed {
		logic signed [POS_BITS-1:0] new_x;
		logic signed [POS_BITS-1:0] new_y;
		logic                       fixed_out;
		logic                       last_node;
	} out_word_t;

	typedef struct packed {
		logic signed [POS_BITS-1:0] x;
		logic signed [POS_BITS-1:0] y;
		logic                       fix;
	} node_t;

	localparam int NODE_W = $bits(node_t);

	typedef struct packed {
		node_t              ctr;
		node_t              nbr;
		logic [REST_W-1:0]  rest;
	} spring_req_t;

	typedef struct packed {
		logic signed [TERM_W-1:0] tx;
		logic signed [TERM_W-1:0] ty;
	} spring_res_t;

endpackage

### rtl/spring_lattice_relax_step_top.sv
// A free interior node works through eight springs, each in the bit-serial square root
// (one root bit a cycle) and divider (one quotient bit a cycle) of the spring unit, and
// then the move states force, scale, step and sum before its word reaches the output.
// Border and fixed slots skip the springs; filling slots give no word. One word is in flight at a time.
// Reset (arst_n low) clears counters, window, state and output valid, and loads the
// register defaults; the line store is not cleared.
module spring_lattice_relax_step_top import slrs_pkg::*; #(
	parameter int GRID_SIZE = GRID_SIZE_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  in_word_t              in_word,
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_word_t             out_word,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int ADDR_W = (GRID_SIZE > 1) ? $clog2(GRID_SIZE) : 1;
	localparam int LINE_W = 2 * NODE_W;
	localparam int WIDE_W = (ACC_W > STEP_W) ? ACC_W + 1 : STEP_W + 1;

	typedef enum logic [9:0] {
		ST_IDLE   = 10'b0000000001,
		ST_READ   = 10'b0000000010,
		ST_CHECK  = 10'b0000000100,
		ST_SPRING = 10'b0000001000,
		ST_ACC    = 10'b0000010000,
		ST_FORCE  = 10'b0000100000,
		ST_SCALE  = 10'b0001000000,
		ST_STEP   = 10'b0010000000,
		ST_SUM    = 10'b0100000000,
		ST_OUT    = 10'b1000000000
	} state_t;

	// shift toward zero, as the force and step scaling define it
	function automatic logic signed [WIDE_W-1:0] tz_shr(input logic signed [WIDE_W-1:0] v,
		input logic [4:0] sh);
		logic [WIDE_W-1:0] m;
		m = v[WIDE_W-1] ? (~v + 1'b1) : v;
		m = m >> sh;
		return v[WIDE_W-1] ? -$signed(m) : $signed(m);
	endfunction

	// configuration registers
	logic [REST_W-1:0]  rest_straight_q, rest_diagonal_q;
	logic [SGAIN_W-1:0] spring_gain_q;
	logic [MGAIN_W-1:0] move_gain_q;
	logic [THR_W-1:0]   step_thr_q;
	logic [DGAIN_W-1:0] damped_gain_q;
	logic [COLS_W-1:0]  grid_cols_q;
	logic [ROWS_W-1:0]  grid_rows_q;

	// control
	state_t             state_q;
	logic [COLS_W-1:0]  col_cnt_q;
	logic [ROWS_W-1:0]  row_cnt_q;
	logic [EMIT_W-1:0]  emit_cnt_q;
	logic [2:0]         k_q;
	logic               out_valid_q;
	node_t              win_q [3][3];

	// per-word payload
	node_t              node_q;
	logic               drain_q;
	logic [COLS_W-1:0]  ec_q;
	logic [ROWS_W-1:0]  er_q;
	logic               last_q;
	logic signed [GPROD_W-1:0] gp_x_q, gp_y_q;
	logic signed [ACC_W-1:0]   acc_x_q, acc_y_q;
	logic signed [FORCE_W-1:0] f_x_q, f_y_q;
	logic signed [STEP_W-1:0]  pm_x_q, pm_y_q, pd_x_q, pd_y_q, step_x_q, step_y_q;
	logic signed [POS_BITS-1:0] nx_q, ny_q;
	out_word_t          out_word_q;

	// sizes in use
	logic [COLS_W-1:0]  cols;
	logic [ROWS_W-1:0]  rows;

	always_comb begin
		if (grid_cols_q < COLS_W'(3)) begin
			cols = COLS_W'(3);
		end else if (32'(grid_cols_q) > GRID_SIZE) begin
			cols = COLS_W'(GRID_SIZE);
		end else begin
			cols = grid_cols_q;
		end
		rows = (grid_rows_q < ROWS_W'(3)) ? ROWS_W'(3) : grid_rows_q;
	end

	assign cfg_ready = 1'b1;

	// input side: wrap the slot counters before the word takes its slot
	logic              accept, ignore, col_wrap;
	logic [COLS_W-1:0] col_n;
	logic [ROWS_W:0]   row_t;
	logic [ROWS_W-1:0] row_n;
	node_t             node_in;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign col_wrap = (col_cnt_q >= cols);
	assign col_n    = col_wrap ? '0 : col_cnt_q;
	assign row_t    = {1'b0, row_cnt_q} + (ROWS_W+1)'(col_wrap);
	assign row_n    = (row_t >= {1'b0, rows}) ? '0 : row_t[ROWS_W-1:0];
	assign ignore   = (in_word.action == ACT_DRAIN) && (emit_cnt_q == '0);

	always_comb begin
		node_in = '0;
		if (in_word.action == ACT_NODE) begin
			node_in.x   = in_word.pos_x;
			node_in.y   = in_word.pos_y;
			node_in.fix = in_word.fixed;
		end
	end

	// line store: one entry per column holds the row above and the row above that
	logic [LINE_W-1:0] line_rd;
	logic              line_rd_en, line_wr_en;
	node_t             up_n, up2_n;

	assign line_rd_en = accept && !ignore;
	assign line_wr_en = (state_q == ST_READ);
	assign up_n       = line_rd[LINE_W-1 -: NODE_W];
	assign up2_n      = line_rd[NODE_W-1:0];

	slrs_line_mem #(
		.DEPTH (GRID_SIZE),
		.WIDTH (LINE_W)
	) u_line_mem (
		.clk     (clk),
		.wr_en   (line_wr_en),
		.wr_addr (ADDR_W'(col_cnt_q)),
		.wr_data ({node_q, up_n}),
		.rd_en   (line_rd_en),
		.rd_addr (ADDR_W'(col_n)),
		.rd_data (line_rd)
	);

	// position of the node leaving the window center, and the next slot
	logic [COLS_W-1:0] ec_v, col_inc;
	logic [ROWS_W-1:0] er_v;
	logic [ROWS_W:0]   row_inc;
	logic              emit_full;

	always_comb begin
		if (col_cnt_q != '0) begin
			ec_v = col_cnt_q - 1'b1;
			er_v = (row_cnt_q != '0) ? row_cnt_q - 1'b1 : rows - 1'b1;
		end else begin
			ec_v = cols - 1'b1;
			er_v = (row_cnt_q >= ROWS_W'(2)) ? row_cnt_q - ROWS_W'(2)
				: row_cnt_q + rows - ROWS_W'(2);
		end
	end

	assign col_inc   = col_cnt_q + 1'b1;
	assign row_inc   = {1'b0, row_cnt_q} + 1'b1;
	assign emit_full = (emit_cnt_q >= ({1'b0, cols} + 1'b1));

	// center node and its eight springs
	node_t       ctr;
	logic        interior;
	logic [2:0]  spr_k;
	spring_req_t spr_req;
	spring_res_t spr_res;
	logic        spr_start, spr_done;

	assign ctr      = win_q[1][1];
	assign interior = !ctr.fix && (er_q != '0) && ((ROWS_W+1)'(er_q) + 2'd2 <= (ROWS_W+1)'(rows))
		&& (ec_q != '0) && ((COLS_W+1)'(ec_q) + 2'd2 <= (COLS_W+1)'(cols));

	assign spr_start = ((state_q == ST_CHECK) && interior)
		|| ((state_q == ST_ACC) && (k_q != '1));
	assign spr_k     = (state_q == ST_ACC) ? k_q + 1'b1 : '0;

	always_comb begin
		spr_req.ctr  = ctr;
		spr_req.rest = spr_k[2] ? rest_diagonal_q : rest_straight_q;
		case (spr_k)
			3'd0:    spr_req.nbr = win_q[0][1];
			3'd1:    spr_req.nbr = win_q[2][1];
			3'd2:    spr_req.nbr = win_q[1][0];
			3'd3:    spr_req.nbr = win_q[1][2];
			3'd4:    spr_req.nbr = win_q[0][0];
			3'd5:    spr_req.nbr = win_q[0][2];
			3'd6:    spr_req.nbr = win_q[2][0];
			default: spr_req.nbr = win_q[2][2];
		endcase
	end

	slrs_spring u_spring (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (spr_start),
		.req    (spr_req),
		.done   (spr_done),
		.res    (spr_res)
	);

	// move arithmetic
	logic signed [WIDE_W-1:0] fx_w, fy_w, smx_w, smy_w, sdx_w, sdy_w;
	logic [STEP_W-1:0]        smx_abs, smy_abs;
	logic signed [STEP_W:0]   sum_x, sum_y;
	logic signed [POS_BITS-1:0] sat_x, sat_y;

	assign fx_w  = tz_shr(WIDE_W'(acc_x_q), 5'd16);
	assign fy_w  = tz_shr(WIDE_W'(acc_y_q), 5'd16);
	assign smx_w = tz_shr(WIDE_W'(pm_x_q), 5'd16);
	assign smy_w = tz_shr(WIDE_W'(pm_y_q), 5'd16);
	assign sdx_w = tz_shr(WIDE_W'(pd_x_q), 5'd24);
	assign sdy_w = tz_shr(WIDE_W'(pd_y_q), 5'd24);
	assign smx_abs = smx_w[STEP_W-1] ? (~smx_w[STEP_W-1:0] + 1'b1) : smx_w[STEP_W-1:0];
	assign smy_abs = smy_w[STEP_W-1] ? (~smy_w[STEP_W-1:0] + 1'b1) : smy_w[STEP_W-1:0];

	assign sum_x = (STEP_W+1)'(ctr.x) + (STEP_W+1)'(step_x_q);
	assign sum_y = (STEP_W+1)'(ctr.y) + (STEP_W+1)'(step_y_q);

	// saturate: the bits above the result's sign must all match it
	always_comb begin
		sat_x = sum_x[POS_BITS-1:0];
		sat_y = sum_y[POS_BITS-1:0];
		if (sum_x[STEP_W:POS_BITS-1] != {(STEP_W-POS_BITS+2){sum_x[STEP_W]}}) begin
			sat_x = sum_x[STEP_W] ? {1'b1, {(POS_BITS-1){1'b0}}} : {1'b0, {(POS_BITS-1){1'b1}}};
		end
		if (sum_y[STEP_W:POS_BITS-1] != {(STEP_W-POS_BITS+2){sum_y[STEP_W]}}) begin
			sat_y = sum_y[STEP_W] ? {1'b1, {(POS_BITS-1){1'b0}}} : {1'b0, {(POS_BITS-1){1'b1}}};
		end
	end

	// output register: hold the word until the far side takes it
	logic out_load;

	assign out_load  = (state_q == ST_OUT) && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rest_straight_q <= REST_STRAIGHT_RST;
			rest_diagonal_q <= REST_DIAGONAL_RST;
			spring_gain_q   <= SPRING_GAIN_RST;
			move_gain_q     <= MOVE_GAIN_RST;
			step_thr_q      <= STEP_THR_RST;
			damped_gain_q   <= DAMPED_GAIN_RST;
			grid_cols_q     <= GRID_COLS_RST;
			grid_rows_q     <= GRID_ROWS_RST;
			state_q         <= ST_IDLE;
			col_cnt_q       <= '0;
			row_cnt_q       <= '0;
			emit_cnt_q      <= '0;
			k_q             <= '0;
			out_valid_q     <= 1'b0;
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					win_q[r][c] <= '0;
				end
			end
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_REST_STRAIGHT: rest_straight_q <= cfg_data[REST_W-1:0];
					REG_REST_DIAGONAL: rest_diagonal_q <= cfg_data[REST_W-1:0];
					REG_SPRING_GAIN:   spring_gain_q   <= cfg_data[SGAIN_W-1:0];
					REG_MOVE_GAIN:     move_gain_q     <= cfg_data[MGAIN_W-1:0];
					REG_STEP_THR:      step_thr_q      <= cfg_data[THR_W-1:0];
					REG_DAMPED_GAIN:   damped_gain_q   <= cfg_data[DGAIN_W-1:0];
					REG_GRID_COLS:     grid_cols_q     <= cfg_data[COLS_W-1:0];
					REG_GRID_ROWS:     grid_rows_q     <= cfg_data[ROWS_W-1:0];
					default: begin
					end
				endcase
			end

			// present a freshly loaded word, drop a word once it is taken
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						col_cnt_q <= col_n;
						row_cnt_q <= row_n;
						// drop a drain while nothing is in flight
						if (!ignore) state_q <= ST_READ;
					end
				end
				ST_READ: begin
					// advance the window one column
					for (int r = 0; r < 3; r++) begin
						win_q[r][0] <= win_q[r][1];
						win_q[r][1] <= win_q[r][2];
					end
					win_q[0][2] <= up2_n;
					win_q[1][2] <= up_n;
					win_q[2][2] <= node_q;
					if (col_inc >= cols) begin
						col_cnt_q <= '0;
						row_cnt_q <= (row_inc >= {1'b0, rows}) ? '0 : row_inc[ROWS_W-1:0];
					end else begin
						col_cnt_q <= col_inc;
					end
					if (!emit_full) begin
						emit_cnt_q <= emit_cnt_q + 1'b1;
						state_q    <= ST_IDLE;
					end else begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					k_q     <= '0;
					state_q <= interior ? ST_SPRING : ST_OUT;
				end
				ST_SPRING: begin
					if (spr_done) state_q <= ST_ACC;
				end
				ST_ACC: begin
					if (k_q == '1) begin
						state_q <= ST_FORCE;
					end else begin
						k_q     <= k_q + 1'b1;
						state_q <= ST_SPRING;
					end
				end
				ST_FORCE: state_q <= ST_SCALE;
				ST_SCALE: state_q <= ST_STEP;
				ST_STEP:  state_q <= ST_SUM;
				ST_SUM:   state_q <= ST_OUT;
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
						// a drain that flushes the frame's last node empties the pipeline
						if (last_q && drain_q) begin
							col_cnt_q  <= '0;
							row_cnt_q  <= '0;
							emit_cnt_q <= '0;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			node_q  <= node_in;
			drain_q <= (in_word.action == ACT_DRAIN);
		end
		if (state_q == ST_READ) begin
			ec_q   <= ec_v;
			er_q   <= er_v;
			last_q <= (er_v == rows - 1'b1) && (ec_v == cols - 1'b1);
		end
		if (state_q == ST_CHECK) begin
			acc_x_q <= '0;
			acc_y_q <= '0;
			nx_q    <= ctr.x;
			ny_q    <= ctr.y;
		end
		if ((state_q == ST_SPRING) && spr_done) begin
			gp_x_q <= spr_res.tx * $signed({1'b0, spring_gain_q});
			gp_y_q <= spr_res.ty * $signed({1'b0, spring_gain_q});
		end
		if (state_q == ST_ACC) begin
			acc_x_q <= acc_x_q + ACC_W'(gp_x_q);
			acc_y_q <= acc_y_q + ACC_W'(gp_y_q);
		end
		if (state_q == ST_FORCE) begin
			f_x_q <= fx_w[FORCE_W-1:0];
			f_y_q <= fy_w[FORCE_W-1:0];
		end
		if (state_q == ST_SCALE) begin
			pm_x_q <= f_x_q * $signed({1'b0, move_gain_q});
			pm_y_q <= f_y_q * $signed({1'b0, move_gain_q});
			pd_x_q <= f_x_q * $signed({1'b0, damped_gain_q});
			pd_y_q <= f_y_q * $signed({1'b0, damped_gain_q});
		end
		if (state_q == ST_STEP) begin
			step_x_q <= (smx_abs > STEP_W'(step_thr_q)) ? sdx_w[STEP_W-1:0] : smx_w[STEP_W-1:0];
			step_y_q <= (smy_abs > STEP_W'(step_thr_q)) ? sdy_w[STEP_W-1:0] : smy_w[STEP_W-1:0];
		end
		if (state_q == ST_SUM) begin
			nx_q <= sat_x;
			ny_q <= sat_y;
		end
		if (out_load) begin
			out_word_q.new_x     <= nx_q;
			out_word_q.new_y     <= ny_q;
			out_word_q.fixed_out <= ctr.fix;
			out_word_q.last_node <= last_q;
		end
	end

	a_acc_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ACC) |-> $past(spr_done))
		else $error("force accumulated without a finished spring");

	a_all_springs: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FORCE) |-> (k_q == '1))
		else $error("force taken before all eight springs");

	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> out_valid_q)
		else $error("loaded result word not presented");

endmodule

### rtl/slrs_line_mem.sv
module slrs_line_mem import slrs_pkg::*; #(
	parameter int DEPTH = GRID_SIZE_DEF,
	parameter int WIDTH = 2 * NODE_W
) (
	input  logic                                  clk,
	input  logic                                  wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                      wr_data,
	input  logic                                  rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                      rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

	// read and write-back of one entry fall in different cycles
	a_no_overlap: assert property (@(posedge clk) wr_en |-> !rd_en)
		else $error("line store read and write in one cycle");

endmodule

### rtl/slrs_spring.sv
module slrs_spring import slrs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  spring_req_t req,
	output logic        done,
	output spring_res_t res
);

	localparam int RM_W  = ROOT_W + 3;
	localparam int CNT_W = $clog2(PROD_W + 1);

	typedef enum logic [7:0] {
		SP_IDLE   = 8'b00000001,
		SP_SQUARE = 8'b00000010,
		SP_SUM    = 8'b00000100,
		SP_ROOT   = 8'b00001000,
		SP_SCALE  = 8'b00010000,
		SP_PROD   = 8'b00100000,
		SP_DIV    = 8'b01000000,
		SP_DONE   = 8'b10000000
	} sp_state_t;

	sp_state_t state_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [MAG_W-1:0]   ax_q, ay_q;
	logic               negx_q, negy_q, sneg_q, zero_q;
	logic [REST_W-1:0]  rest_q;
	logic [SQ_W-1:0]    sqx_q, sqy_q, rad_q;
	logic [RM_W-1:0]    rem_q;
	logic [ROOT_W-1:0]  root_q;
	logic [SMAG_W-1:0]  as_q;
	logic [PROD_W-1:0]  dvx_q, dvy_q;
	logic [ROOT_W-1:0]  rmx_q, rmy_q;

	logic signed [MAG_W-1:0]  dx, dy;
	logic [MAG_W-1:0]         ax, ay;
	logic [RM_W-1:0]          rt_r, rt_trial;
	logic                     rt_ge;
	logic signed [TERM_W-1:0] s_v;
	logic [TERM_W-1:0]        s_abs;
	logic [ROOT_W:0]          dvx_r, dvy_r, dvx_d, dvy_d;
	logic                     gex, gey;
	logic [TERM_W-1:0]        qx, qy;

	assign dx = MAG_W'(req.nbr.x) - MAG_W'(req.ctr.x);
	assign dy = MAG_W'(req.nbr.y) - MAG_W'(req.ctr.y);
	assign ax = dx[MAG_W-1] ? (~dx + 1'b1) : dx;
	assign ay = dy[MAG_W-1] ? (~dy + 1'b1) : dy;

	// one root bit per cycle
	assign rt_r     = {rem_q[RM_W-3:0], rad_q[SQ_W-1 -: 2]};
	assign rt_trial = {{(RM_W-ROOT_W-2){1'b0}}, root_q, 2'b01};
	assign rt_ge    = (rt_r >= rt_trial);

	assign s_v   = $signed(TERM_W'(root_q)) - $signed(TERM_W'(rest_q));
	assign s_abs = s_v[TERM_W-1] ? (~s_v + 1'b1) : s_v;

	// one quotient bit per cycle on each axis
	assign dvx_r = {rmx_q, dvx_q[PROD_W-1]};
	assign dvy_r = {rmy_q, dvy_q[PROD_W-1]};
	assign gex   = (dvx_r >= {1'b0, root_q});
	assign gey   = (dvy_r >= {1'b0, root_q});
	assign dvx_d = dvx_r - {1'b0, root_q};
	assign dvy_d = dvy_r - {1'b0, root_q};

	assign qx = TERM_W'(dvx_q[SMAG_W-1:0]);
	assign qy = TERM_W'(dvy_q[SMAG_W-1:0]);

	always_comb begin
		res.tx = '0;
		res.ty = '0;
		if (!zero_q) begin
			res.tx = (negx_q ^ sneg_q) ? -$signed(qx) : $signed(qx);
			res.ty = (negy_q ^ sneg_q) ? -$signed(qy) : $signed(qy);
		end
	end

	assign done = (state_q == SP_DONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SP_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				SP_IDLE: begin
					if (start) state_q <= SP_SQUARE;
				end
				SP_SQUARE: state_q <= SP_SUM;
				SP_SUM: begin
					cnt_q   <= CNT_W'(ROOT_W);
					state_q <= SP_ROOT;
				end
				SP_ROOT: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CNT_W'(1)) state_q <= SP_SCALE;
				end
				SP_SCALE: begin
					state_q <= (root_q == '0) ? SP_DONE : SP_PROD;
				end
				SP_PROD: begin
					cnt_q   <= CNT_W'(PROD_W);
					state_q <= SP_DIV;
				end
				SP_DIV: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CNT_W'(1)) state_q <= SP_DONE;
				end
				SP_DONE: state_q <= SP_IDLE;
				default: state_q <= SP_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			SP_IDLE: begin
				if (start) begin
					ax_q   <= ax;
					ay_q   <= ay;
					negx_q <= dx[MAG_W-1];
					negy_q <= dy[MAG_W-1];
					rest_q <= req.rest;
				end
			end
			SP_SQUARE: begin
				sqx_q <= SQ_W'(ax_q * ax_q);
				sqy_q <= SQ_W'(ay_q * ay_q);
			end
			SP_SUM: begin
				rad_q  <= sqx_q + sqy_q;
				rem_q  <= '0;
				root_q <= '0;
			end
			SP_ROOT: begin
				rad_q <= {rad_q[SQ_W-3:0], 2'b00};
				if (rt_ge) begin
					rem_q  <= rt_r - rt_trial;
					root_q <= {root_q[ROOT_W-2:0], 1'b1};
				end else begin
					rem_q  <= rt_r;
					root_q <= {root_q[ROOT_W-2:0], 1'b0};
				end
			end
			SP_SCALE: begin
				zero_q <= (root_q == '0);
				sneg_q <= s_v[TERM_W-1];
				as_q   <= s_abs[SMAG_W-1:0];
			end
			SP_PROD: begin
				dvx_q <= PROD_W'(ax_q * as_q);
				dvy_q <= PROD_W'(ay_q * as_q);
				rmx_q <= '0;
				rmy_q <= '0;
			end
			SP_DIV: begin
				dvx_q <= {dvx_q[PROD_W-2:0], gex};
				dvy_q <= {dvy_q[PROD_W-2:0], gey};
				rmx_q <= gex ? dvx_d[ROOT_W-1:0] : dvx_r[ROOT_W-1:0];
				rmy_q <= gey ? dvy_d[ROOT_W-1:0] : dvy_r[ROOT_W-1:0];
			end
			default: begin
			end
		endcase
	end

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> (state_q == SP_IDLE))
		else $error("spring unit started while busy");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == SP_DONE) |=> (state_q == SP_IDLE))
		else $error("spring done held longer than one cycle");

endmodule
